/* design/nzc_pkg.sv */
package nzc_pkg;

    // Geometry of the coordinate counter.
    localparam int MAX_RANK    = 6;
    localparam int COORD_WIDTH = 32;
    localparam int SIZE_WIDTH  = 32;
    localparam int HIT_WIDTH   = 32;
    localparam int RANK_WIDTH  = 3;
    localparam int ELEM_WIDTH  = 64;
    localparam int DIM_IDX_W   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_RANK  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE0 = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE5 = CFG_INDEX_W'(MAX_RANK);
    localparam logic [CFG_INDEX_W-1:0] REG_KIND  = CFG_INDEX_W'(7);

    // Result channel payload width, rounded up to whole bytes.
    localparam int M_DATA_BITS = MAX_RANK * COORD_WIDTH + HIT_WIDTH;
    localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

    // Element encodings for the truth test.
    typedef enum logic [1:0] {
        KIND_INT  = 2'd0,
        KIND_F32  = 2'd1,
        KIND_F64  = 2'd2,
        KIND_BF16 = 2'd3
    } kind_t;

    typedef logic [MAX_RANK-1:0][COORD_WIDTH-1:0] coord_vec_t;

    // Configuration register contents.
    typedef struct packed {
        logic [RANK_WIDTH-1:0]                rank;
        logic [MAX_RANK-1:0][SIZE_WIDTH-1:0]  size;
        kind_t                                kind;
    } cfg_t;

    // Counter results for the element currently being processed.
    typedef struct packed {
        coord_vec_t             coords;
        logic                   last;
        logic [HIT_WIDTH-1:0]   hits;
    } odo_status_t;

endpackage

/* design/nonzero_coordinate_stream.sv */
// Streams the coordinates of the nonzero elements of a tensor. Elements enter
// one per transfer in row-major order; a mixed-radix counter sized by the
// dimension registers tracks their position. A transfer is emitted for every
// element that tests true and always for the last element of the tensor
// (tlast set, tuser clear if that element is zero); the counter and the hit
// count then restart. The block takes one element per clock cycle while the
// result channel is not stalled: each element is held in the input register,
// and the counter step, truth test and result formatting settle from it into
// the output register. Write configuration only while no element is in
// flight.
module nonzero_coordinate_stream
    import nzc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [ELEM_WIDTH-1:0]   s_tdata,    // element_bits

    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,    // coord0..coord5, hit_count
    output logic                    m_tuser,    // is_hit
    output logic                    m_tlast     // end_of_tensor
);

    cfg_t                   cfg;
    odo_status_t            status;
    logic                   elem_true;
    logic                   out_free;
    logic                   step;

    logic                   in_valid_reg;
    logic [ELEM_WIDTH-1:0]  in_bits_reg;

    logic                   out_valid_reg;
    coord_vec_t             out_coords_reg;
    logic                   out_hit_reg;
    logic                   out_last_reg;
    logic [HIT_WIDTH-1:0]   out_count_reg;

    nzc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    nzc_truth u_truth (
        .kind         (cfg.kind),
        .element_bits (in_bits_reg),
        .is_true      (elem_true)
    );

    nzc_odometer u_odo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (step),
        .hit     (elem_true),
        .status  (status)
    );

    // The held element moves on once the output register can take a result.
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_bits_reg <= s_tdata;
        end
    end

    // Output register: loaded for a hit or for the tensor's last element.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step && (elem_true || status.last);
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_coords_reg <= elem_true ? status.coords : '0;
            out_hit_reg    <= elem_true;
            out_last_reg   <= status.last;
            out_count_reg  <= status.hits;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_count_reg, out_coords_reg});
    assign m_tuser  = out_hit_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* design/nzc_cfg_regs.sv */
module nzc_cfg_regs
    import nzc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic [DIM_IDX_W-1:0] dim_idx;

    assign dim_idx = DIM_IDX_W'(cfg_index - REG_SIZE0);

    // Decode one register write; unknown indexes are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_RANK: begin
                    cfg_next.rank = cfg_wdata[RANK_WIDTH-1:0];
                end
                REG_KIND: begin
                    cfg_next.kind = kind_t'(cfg_wdata[1:0]);
                end
                default: begin
                    if (cfg_index >= REG_SIZE0 && cfg_index <= REG_SIZE5) begin
                        cfg_next.size[dim_idx] = cfg_wdata[SIZE_WIDTH-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rank <= RANK_WIDTH'(1);
            for (int d = 0; d < MAX_RANK; d++) begin
                cfg_reg.size[d] <= SIZE_WIDTH'(1);
            end
            cfg_reg.kind <= KIND_INT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/nzc_truth.sv */
module nzc_truth
    import nzc_pkg::*;
(
    input  kind_t                   kind,
    input  logic [ELEM_WIDTH-1:0]   element_bits,
    output logic                    is_true
);

    // Any magnitude bit set; float kinds skip the sign bit.
    always_comb begin
        unique case (kind)
            KIND_INT:  is_true = |element_bits;
            KIND_F32:  is_true = |element_bits[30:0];
            KIND_F64:  is_true = |element_bits[62:0];
            KIND_BF16: is_true = |element_bits[14:0];
        endcase
    end

endmodule

/* design/nzc_odometer.sv */
module nzc_odometer
    import nzc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        step,
    input  logic        hit,
    output odo_status_t status
);

    localparam int CMP_W = (COORD_WIDTH > SIZE_WIDTH) ? COORD_WIDTH : SIZE_WIDTH;

    logic [COORD_WIDTH-1:0] digit_reg  [MAX_RANK];
    logic [COORD_WIDTH-1:0] digit_next [MAX_RANK];
    logic [HIT_WIDTH-1:0]   hits_reg;
    logic [HIT_WIDTH-1:0]   hits_next;

    logic [RANK_WIDTH-1:0]  rank_eff;
    logic [MAX_RANK-1:0]    active;
    logic [MAX_RANK-1:0]    wrap;
    logic [MAX_RANK:0]      carry;
    logic [SIZE_WIDTH-1:0]  size_m1 [MAX_RANK];
    coord_vec_t             digit_eff;

    // Clamp the rank into the supported range.
    always_comb begin
        if (cfg.rank == '0) begin
            rank_eff = RANK_WIDTH'(1);
        end else if (cfg.rank > RANK_WIDTH'(MAX_RANK)) begin
            rank_eff = RANK_WIDTH'(MAX_RANK);
        end else begin
            rank_eff = cfg.rank;
        end
    end

    // Per-digit wrap test, then the carry ripples from the innermost digit out.
    always_comb begin
        for (int d = 0; d < MAX_RANK; d++) begin
            active[d]    = RANK_WIDTH'(d) < rank_eff;
            digit_eff[d] = active[d] ? digit_reg[d] : '0;
            size_m1[d]   = (cfg.size[d] == '0) ? '0 : cfg.size[d] - SIZE_WIDTH'(1);
            wrap[d]      = (CMP_W'(digit_eff[d]) >= CMP_W'(size_m1[d])) || (&digit_eff[d]);
        end
        carry[MAX_RANK] = 1'b1;
        for (int d = MAX_RANK - 1; d >= 0; d--) begin
            carry[d] = carry[d+1] & (~active[d] | wrap[d]);
        end
    end

    // Saturating hit count including the current element.
    assign hits_next = (hit && hits_reg != '1) ? hits_reg + HIT_WIDTH'(1) : hits_reg;

    // Next digit values; the tensor end returns everything to zero.
    always_comb begin
        for (int d = 0; d < MAX_RANK; d++) begin
            if (carry[0] || !active[d]) begin
                digit_next[d] = '0;
            end else if (carry[d+1]) begin
                digit_next[d] = wrap[d] ? '0 : digit_eff[d] + COORD_WIDTH'(1);
            end else begin
                digit_next[d] = digit_eff[d];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < MAX_RANK; d++) begin
                digit_reg[d] <= '0;
            end
            hits_reg <= '0;
        end else if (step) begin
            for (int d = 0; d < MAX_RANK; d++) begin
                digit_reg[d] <= digit_next[d];
            end
            hits_reg <= carry[0] ? '0 : hits_next;
        end
    end

    assign status.coords = digit_eff;
    assign status.last   = carry[0];
    assign status.hits   = hits_next;

endmodule

/* dv/tb_top.sv */
module tb_top;
    import nzc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int STEADY_ITEMS   = 1600;

    // One coordinate result as the block should present it.
    typedef struct packed {
        coord_vec_t             coords;
        logic                   hit;
        logic                   last;
        logic [HIT_WIDTH-1:0]   count;
    } nz_result_t;

    typedef logic [MAX_RANK-1:0][SIZE_WIDTH-1:0] shape_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_we;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [ELEM_WIDTH-1:0]   s_tdata;    // element_bits
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;    // coord0..coord5, hit_count
    logic                    m_tuser;    // is_hit
    logic                    m_tlast;    // end_of_tensor

    // Mirror of the block's registers and counter state.
    logic [RANK_WIDTH-1:0]   model_rank;
    logic [SIZE_WIDTH-1:0]   model_size [MAX_RANK];
    kind_t                   model_kind;
    logic [COORD_WIDTH-1:0]  model_digit [MAX_RANK];
    logic [HIT_WIDTH-1:0]    model_hits;

    nz_result_t pending_coords [$];
    int         mismatches;
    int         quiet_cycles;
    bit         steady_tail;
    int         send_gap_odds;
    int         sink_stall_odds;

    nonzero_coordinate_stream dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Truth test of one element under the current element kind.
    function automatic bit element_is_true(input logic [ELEM_WIDTH-1:0] bits);
        case (model_kind)
            KIND_F32:  return |bits[30:0];
            KIND_F64:  return |bits[62:0];
            KIND_BF16: return |bits[14:0];
            default:   return |bits;
        endcase
    endfunction

    // Step the coordinate counter for one accepted element and queue the
    // result that it causes, if any.
    task automatic predict_coords(input logic [ELEM_WIDTH-1:0] bits);
        int                     rank;
        int                     i;
        int                     d;
        bit                     hit;
        bit                     wrapped;
        coord_vec_t             snap;
        logic [SIZE_WIDTH-1:0]  radix;
        logic [COORD_WIDTH:0]   bumped;
        nz_result_t             res;
        rank = (model_rank == 0) ? 1 : ((model_rank > MAX_RANK) ? MAX_RANK : model_rank);
        for (i = rank; i < MAX_RANK; i++) model_digit[i] = '0;
        for (i = 0; i < MAX_RANK; i++) snap[i] = model_digit[i];
        hit = element_is_true(bits);
        if (hit && model_hits != '1) model_hits = model_hits + 1'b1;

        // Odometer step from the innermost dimension outward.
        wrapped = 1'b1;
        for (d = rank - 1; d >= 0 && wrapped; d--) begin
            radix  = (model_size[d] == 0) ? SIZE_WIDTH'(1) : model_size[d];
            bumped = {1'b0, model_digit[d]} + 1'b1;
            if (bumped >= {1'b0, radix} || bumped[COORD_WIDTH]) begin
                model_digit[d] = '0;
            end else begin
                model_digit[d] = bumped[COORD_WIDTH-1:0];
                wrapped = 1'b0;
            end
        end

        if (hit || wrapped) begin
            res.coords = hit ? snap : '0;
            res.hit    = hit;
            res.last   = wrapped;
            res.count  = model_hits;
            pending_coords = {pending_coords, res};
        end
        if (wrapped) begin
            for (i = 0; i < MAX_RANK; i++) model_digit[i] = '0;
            model_hits = '0;
        end
    endtask

    function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %h, got %h", what, want, got);
    endfunction

    // Register write; called at a falling edge while the block is idle.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we    = 1'b0;
        case (index)
            REG_RANK: model_rank = value[RANK_WIDTH-1:0];
            REG_KIND: model_kind = kind_t'(value[1:0]);
            default:  model_size[index - REG_SIZE0] = value[SIZE_WIDTH-1:0];
        endcase
    endtask

    // Write every register; dimension 0 sits in the low word of dims.
    task automatic set_shape(input logic [RANK_WIDTH-1:0] rank, input shape_t dims,
                             input kind_t kind);
        int d;
        write_register(REG_RANK, CFG_DATA_W'(rank));
        for (d = 0; d < MAX_RANK; d++)
            write_register(REG_SIZE0 + CFG_INDEX_W'(d), dims[d]);
        write_register(REG_KIND, CFG_DATA_W'(kind));
    endtask

    // Offer one element and hold it until the block takes the transfer.
    task automatic send_element(input logic [ELEM_WIDTH-1:0] bits);
        if (!steady_tail && $urandom_range(0, 7) < send_gap_odds) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = bits;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_coords(bits);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Wait until every expected result has arrived, then let the pipeline
    // settle so that elements without a result have left it too.
    task automatic wait_for_drain();
        while (pending_coords.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Out of reset: rank 1 and size 1, so every element closes a tensor.
    task automatic test_reset_defaults();
        send_element('0);
        send_element('1);
        wait_for_drain();
    endtask

    // Truth test per kind: sign bit alone, bits above the float width, NaN.
    task automatic test_element_kinds();
        logic [ELEM_WIDTH-1:0] probes [12];
        kind_t                 kinds [4];
        int                    k;
        probes = '{64'h8000_0000_0000_0000, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'h0000_0000_8000_0000, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_7FC0_0000,
                   64'h8000_0000_0000_0000, 64'h7FF8_0000_0000_0000, 64'h1,
                   64'h0000_0000_0000_8000, 64'hFFFF_FFFF_FFFF_0000, 64'h0000_0000_0000_7FC0};
        kinds  = '{KIND_INT, KIND_F32, KIND_F64, KIND_BF16};
        set_shape(RANK_WIDTH'(2), {32'd1, 32'd1, 32'd1, 32'd1, 32'd3, 32'd2}, KIND_INT);
        for (k = 0; k < 12; k++) begin
            if (k % 3 == 0) begin
                wait_for_drain();
                write_register(REG_KIND, CFG_DATA_W'(kinds[k / 3]));
            end
            send_element(probes[k]);
        end
        wait_for_drain();
    endtask

    // Rank 0 acts as 1, rank 7 as the maximum, and a zero size as 1.
    task automatic test_rank_limits();
        set_shape(RANK_WIDTH'(0), {32'd7, 32'd7, 32'd7, 32'd7, 32'd7, 32'd0}, KIND_INT);
        send_element(64'd5);
        send_element('0);
        wait_for_drain();
        set_shape(RANK_WIDTH'(7), {32'd2, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1}, KIND_INT);
        send_element(64'd1);
        send_element('0);
        send_element(64'd1);
        wait_for_drain();
    endtask

    // Shrinking a dimension below its digit, then dropping the rank, while
    // a tensor is half done.
    task automatic test_reshape_mid_tensor();
        set_shape(RANK_WIDTH'(2), {32'd1, 32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                  KIND_F64);
        repeat (3) send_element(64'h3FF0_0000_0000_0000);
        wait_for_drain();
        write_register(REG_SIZE0 + CFG_INDEX_W'(1), 32'd2);
        send_element(64'h7FF0_0000_0000_0000);
        wait_for_drain();
        write_register(REG_RANK, 32'd1);
        write_register(REG_SIZE0, 32'd2);
        send_element(64'h1);
        send_element(64'h8000_0000_0000_0000);
        wait_for_drain();
    endtask

    // Random shapes and kinds, mostly whole small tensors, some partial ones
    // and a few with a huge outer dimension that never closes.
    task automatic test_random_tensors();
        int                     sent;
        int                     active;
        int                     elements;
        int                     cap;
        int                     count;
        int                     d;
        bit                     huge;
        logic [RANK_WIDTH-1:0]  rank;
        shape_t                 dims;
        kind_t                  kind;
        logic [ELEM_WIDTH-1:0]  bits;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= STEADY_ITEMS) begin
                steady_tail = 1'b1;
            end else begin
                send_gap_odds   = $urandom_range(0, 3);
                sink_stall_odds = $urandom_range(0, 3);
            end

            rank = RANK_WIDTH'($urandom_range(1, MAX_RANK));
            if ($urandom_range(0, 9) == 0) rank = $urandom_range(0, 1) ? '0 : '1;
            active = (rank == 0) ? 1 : ((rank > MAX_RANK) ? MAX_RANK : rank);
            kind = kind_t'($urandom_range(0, 3));

            // Keep the element count of a tensor small.
            elements = 1;
            for (d = 0; d < MAX_RANK; d++) begin
                if (d < active) begin
                    cap = 48 / elements;
                    if (cap > 5) cap = 5;
                    dims[d] = $urandom_range(1, cap);
                    elements *= dims[d];
                    if (dims[d] == 1 && $urandom_range(0, 3) == 0) dims[d] = '0;
                end else begin
                    dims[d] = $urandom;
                end
            end
            huge = ($urandom_range(0, 9) == 0);
            if (huge) dims[0] = $urandom_range(0, 1) ? '1 : $urandom;

            if (huge) count = $urandom_range(1, 20);
            else if ($urandom_range(0, 4) == 0) count = $urandom_range(1, elements);
            else count = elements * $urandom_range(1, 2);

            set_shape(rank, dims, kind);
            repeat (count) begin
                case ($urandom_range(0, 5))
                    0, 1: bits = '0;
                    2: bits = {$urandom, $urandom};
                    3: bits = ELEM_WIDTH'(1) << $urandom_range(0, ELEM_WIDTH - 1);
                    4: begin
                        // Sign and upper bits only: false for the float kinds.
                        bits = {$urandom, $urandom};
                        case (kind)
                            KIND_F32:  bits[30:0] = '0;
                            KIND_F64:  bits[62:0] = '0;
                            KIND_BF16: bits[14:0] = '0;
                            default:   bits = '0;
                        endcase
                    end
                    default: bits = '1;
                endcase
                send_element(bits);
            end
            sent += count;
            wait_for_drain();
        end
    endtask

    // Result sink with random stall bursts.
    initial begin : sink_stalls
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else if (!steady_tail && $urandom_range(0, 15) < sink_stall_odds) begin
                m_tready = 1'b0;
                stall = $urandom_range(1, 11) - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest expected one.
    always @(posedge aclk) begin : check_results
        nz_result_t want;
        int         i;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_coords.size() == 0) begin
                flag_mismatch("result with none pending, hit_count", '0,
                              m_tdata[MAX_RANK*COORD_WIDTH +: HIT_WIDTH]);
            end else begin
                want = pending_coords.pop_front();
                for (i = 0; i < MAX_RANK; i++)
                    if (m_tdata[i*COORD_WIDTH +: COORD_WIDTH] !== want.coords[i])
                        flag_mismatch($sformatf("coord%0d", i), want.coords[i],
                                      m_tdata[i*COORD_WIDTH +: COORD_WIDTH]);
                if (m_tdata[MAX_RANK*COORD_WIDTH +: HIT_WIDTH] !== want.count)
                    flag_mismatch("hit_count", want.count,
                                  m_tdata[MAX_RANK*COORD_WIDTH +: HIT_WIDTH]);
                if (m_tuser !== want.hit)
                    flag_mismatch("is_hit", 32'(want.hit), 32'(m_tuser));
                if (m_tlast !== want.last)
                    flag_mismatch("end_of_tensor", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    // End the run if no transfer moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : run_tests
        int i;
        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        mismatches      = 0;
        quiet_cycles    = 0;
        steady_tail     = 1'b0;
        send_gap_odds   = 2;
        sink_stall_odds = 2;

        // Register and counter state after reset.
        model_rank = RANK_WIDTH'(1);
        model_kind = KIND_INT;
        model_hits = '0;
        for (i = 0; i < MAX_RANK; i++) begin
            model_size[i]  = SIZE_WIDTH'(1);
            model_digit[i] = '0;
        end

        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_element_kinds();
        test_rank_limits();
        test_reshape_mid_tensor();
        test_random_tensors();

        wait_for_drain();
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && pending_coords.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
